FILE: rtl/sts_pkg.sv
// Shared codes and field widths for the simplex tableau solver.
// No dependencies; the interfaces, the solver top level and the testbench import this package.
package sts_pkg;

    // Item operation codes.
    localparam logic [1:0] OP_LOAD_COEF = 2'd0;
    localparam logic [1:0] OP_LOAD_BOUND = 2'd1;
    localparam logic [1:0] OP_LOAD_OBJ = 2'd2;
    localparam logic [1:0] OP_SOLVE = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OPTIMAL = 2'd0;
    localparam logic [1:0] ST_UNBOUNDED = 2'd1;
    localparam logic [1:0] ST_ITER_LIMIT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NUM_CONSTRAINTS = 2'd0;
    localparam logic [1:0] CFG_NUM_VARIABLES = 2'd1;
    localparam logic [1:0] CFG_ITERATION_CAP = 2'd2;

    // Field widths.
    localparam int OP_W = 2;
    localparam int IDX_W = 4;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;
    localparam int CNT_W = 5;
    localparam int PIV_W = 16;

    // Configuration reset values.
    localparam logic [CNT_W-1:0] RST_NUM_CONSTRAINTS = 5'd1;
    localparam logic [CNT_W-1:0] RST_NUM_VARIABLES = 5'd1;
    localparam logic [PIV_W-1:0] RST_ITERATION_CAP = 16'd1024;

    // Configuration register file.
    typedef struct packed {
        logic [CNT_W-1:0] num_constraints;
        logic [CNT_W-1:0] num_variables;
        logic [PIV_W-1:0] iteration_cap;
    } t_cfg;

endpackage

FILE: rtl/sts_ifs.sv
// Valid/ready channel interfaces of the simplex tableau solver.
// Depends on sts_pkg for field widths.
interface sts_item_if import sts_pkg::*; #(parameter int VALUE_WIDTH = 32);
    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        op;
    logic [IDX_W-1:0]       row_index;
    logic [IDX_W-1:0]       column_index;
    logic [VALUE_WIDTH-1:0] value;
    modport source (output valid, op, row_index, column_index, value, input ready);
    modport sink (input valid, op, row_index, column_index, value, output ready);
endinterface

interface sts_res_if import sts_pkg::*; #(parameter int VALUE_WIDTH = 32);
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [VALUE_WIDTH-1:0] objective_value;
    logic [PIV_W-1:0]       pivot_count;
    modport source (output valid, status, objective_value, pivot_count, input ready);
    modport sink (input valid, status, objective_value, pivot_count, output ready);
endinterface

interface sts_cfg_if import sts_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/sts_mul.sv
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// Standalone; used by the solver top level for ratio tests and pivot updates.
module sts_mul #(
    parameter int W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic           o_done,
    output logic [2*W-1:0] o_p
);
    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic           r_busy, r_done;
    logic [CW-1:0]  r_cnt;
    logic [2*W-1:0] r_acc, r_mc;
    logic [W-1:0]   r_mp;

    // Control: busy while the multiplier bits are stepped, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: add the shifted multiplicand for each set multiplier bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_mc <= {{W{1'b0}}, i_a};
            r_mp <= i_b;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= {r_mc[2*W-2:0], 1'b0};
            r_mp <= {1'b0, r_mp[W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_p = r_acc;
endmodule

FILE: rtl/sts_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; computes the pivot row quotient a * 2^16 / pe for the solver.
module sts_div #(
    parameter int W = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [W+15:0]   i_num,
    input  logic [W-1:0]    i_den,
    output logic            o_done,
    output logic [W+15:0]   o_quo
);
    localparam int NW = W + 16;
    localparam int CW = $clog2(NW);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem, r_den;
    logic [NW-1:0] r_num;
    logic [W:0]    trial;
    logic          fits;

    // One trial subtraction per cycle.
    assign trial = {r_rem, r_num[NW-1]};
    assign fits = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend bits shift out at the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? W'(trial - {1'b0, r_den}) : trial[W-1:0];
            r_num <= {r_num[NW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo = r_num;
endmodule

FILE: rtl/simplex_tableau_solver.sv
// Simplex tableau solver: dense tableau memory, sequencer and pivot arithmetic.
// Depends on sts_pkg, sts_ifs, sts_mul and sts_div.
//
// Load items are taken one per cycle while the sequencer is idle and are
// written straight into the tableau memory. A solve item runs the simplex
// method: each pivot does an objective-row scan, a ratio test, a copy of the
// pivot column and a column-by-column row update, with the serial multiplier
// and divider doing the products and quotients. After reset and after every
// solve the tableau memory is cleared one entry a cycle, while no item is
// taken; configuration writes are taken at all times.
module simplex_tableau_solver import sts_pkg::*; #(
    parameter int MAX_CONSTRAINTS = 16,
    parameter int MAX_VARIABLES = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sts_item_if.sink   i_item,
    sts_cfg_if.sink    i_cfg,
    sts_res_if.source  o_res
);
    localparam int W = VALUE_WIDTH;
    localparam int T_ROWS = MAX_CONSTRAINTS + 1;
    localparam int T_COLS = MAX_CONSTRAINTS + MAX_VARIABLES + 1;
    localparam int RHS_COL = T_COLS - 1;
    localparam int DEPTH = T_ROWS * T_COLS;
    localparam int AW = $clog2(DEPTH);
    localparam int RW = $clog2(T_ROWS);
    localparam int CW = $clog2(T_COLS);
    localparam int PW = 2 * W;
    localparam int SW = PW - 16;
    localparam int NW = W + 16;
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE = (W >= 18) ? W'(65536) : VMAX;

    localparam logic [4:0] S_CLR = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_SLK = 5'd2;
    localparam logic [4:0] S_CRD = 5'd3;
    localparam logic [4:0] S_CUS = 5'd4;
    localparam logic [4:0] S_CDEC = 5'd5;
    localparam logic [4:0] S_RTR = 5'd6;
    localparam logic [4:0] S_RTU = 5'd7;
    localparam logic [4:0] S_RBR = 5'd8;
    localparam logic [4:0] S_RBU = 5'd9;
    localparam logic [4:0] S_RM1 = 5'd10;
    localparam logic [4:0] S_RM2 = 5'd11;
    localparam logic [4:0] S_RNX = 5'd12;
    localparam logic [4:0] S_CVR = 5'd13;
    localparam logic [4:0] S_CVU = 5'd14;
    localparam logic [4:0] S_PJR = 5'd15;
    localparam logic [4:0] S_PJU = 5'd16;
    localparam logic [4:0] S_PDV = 5'd17;
    localparam logic [4:0] S_PIR = 5'd18;
    localparam logic [4:0] S_PIU = 5'd19;
    localparam logic [4:0] S_PMW = 5'd20;
    localparam logic [4:0] S_PIN = 5'd21;
    localparam logic [4:0] S_OBJ = 5'd22;
    localparam logic [4:0] S_OBU = 5'd23;

    function automatic logic [AW-1:0] f_addr(input logic [RW-1:0] row,
                                             input logic [CW-1:0] col);
        f_addr = AW'(AW'(row) * AW'(T_COLS) + AW'(col));
    endfunction

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] x);
        f_mag = x[W-1] ? W'(-x) : x;
    endfunction

    function automatic logic [W-1:0] f_sat_sub(input logic [W-1:0] x,
                                               input logic [W-1:0] y);
        logic [W:0] d;
        d = {x[W-1], x} - {y[W-1], y};
        if (d[W] != d[W-1]) begin
            f_sat_sub = d[W] ? VMIN : VMAX;
        end else begin
            f_sat_sub = d[W-1:0];
        end
    endfunction

    // Configuration registers; the write channel is always ready.
    t_cfg r_cfg;
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_constraints <= RST_NUM_CONSTRAINTS;
            r_cfg.num_variables <= RST_NUM_VARIABLES;
            r_cfg.iteration_cap <= RST_ITERATION_CAP;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_NUM_CONSTRAINTS: r_cfg.num_constraints <= i_cfg.data[CNT_W-1:0];
                CFG_NUM_VARIABLES: r_cfg.num_variables <= i_cfg.data[CNT_W-1:0];
                CFG_ITERATION_CAP: r_cfg.iteration_cap <= i_cfg.data[PIV_W-1:0];
                default: ;
            endcase
        end
    end

    // Tableau memory and pivot-column copy memory, registered reads.
    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] cmem [T_ROWS];
    logic          we, cwe;
    logic [AW-1:0] waddr, raddr;
    logic [W-1:0]  wdata, r_rdata, r_crdata;
    logic [RW-1:0] caddr;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cwe) begin
            cmem[caddr] <= r_rdata;
        end
        r_crdata <= cmem[caddr];
    end

    // Sequencer registers.
    logic [4:0]       r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [RW-1:0]    r_m, n_m, r_i, n_i, r_pr, n_pr, r_brow, n_brow;
    logic [CW-1:0]    r_n, n_n, r_k, n_k, r_pc, n_pc, r_bcol, n_bcol, r_j, n_j;
    logic             r_cok, n_cok, r_rok, n_rok, r_neg, n_neg;
    logic [W-1:0]     r_bestv, n_bestv, r_t, n_t, r_b, n_b, r_tr, n_tr, r_br, n_br;
    logic [W-1:0]     r_pe, n_pe, r_rowv, n_rowv, r_old, n_old;
    logic [PW:0]      r_p1, n_p1;
    logic [PIV_W-1:0] r_piv, n_piv;
    logic             r_ovalid, n_ovalid;
    logic [1:0]       r_ostat, n_ostat, r_stat, n_stat;
    logic [W-1:0]     r_oobj, n_oobj;
    logic [PIV_W-1:0] r_opiv, n_opiv;

    // Arithmetic units.
    logic           mul_start, mul_done, div_start, div_done;
    logic [W-1:0]   mul_a, mul_b;
    logic [PW-1:0]  mul_p;
    logic [NW-1:0]  div_num, div_quo;

    sts_mul #(.W(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_p(mul_p)
    );

    sts_div #(.W(W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(r_pe), .o_done(div_done), .o_quo(div_quo)
    );

    // Scan column for objective-row position k: slack columns, then variables.
    logic [CW-1:0] kcol;
    assign kcol = (CW'(r_k) < CW'(r_m)) ? r_k : CW'(CW'(MAX_CONSTRAINTS) + r_k - CW'(r_m));

    // Signed exact product from the magnitude product of the ratio test.
    logic [PW:0] sprod;
    assign sprod = r_neg ? (PW + 1)'(-{1'b0, mul_p}) : {1'b0, mul_p};

    // Saturated Q16.16 product of the pivot update (floor rounding).
    logic [PW-1:0] qm_p;
    logic [SW-1:0] qm_s, qm_lim, qm_sat;
    logic          qm_neg;
    logic [W-1:0]  qm_res;
    always_comb begin
        qm_p = r_neg ? mul_p + PW'(16'hffff) : mul_p;
        qm_s = qm_p[PW-1:16];
        qm_neg = r_neg && (qm_s != '0);
        qm_lim = qm_neg ? (SW'(1) << (W - 1)) : ((SW'(1) << (W - 1)) - SW'(1));
        qm_sat = (qm_s > qm_lim) ? qm_lim : qm_s;
        qm_res = qm_neg ? W'(-qm_sat[W-1:0]) : qm_sat[W-1:0];
    end

    // Saturated quotient of the pivot row.
    logic [NW-1:0] qd_lim, qd_sat;
    logic [W-1:0]  qd_res;
    always_comb begin
        qd_lim = r_neg ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - NW'(1));
        qd_sat = (div_quo > qd_lim) ? qd_lim : div_quo;
        qd_res = r_neg ? W'(-qd_sat[W-1:0]) : qd_sat[W-1:0];
    end

    // Load decode.
    logic ld_row_ok, ld_col_ok;
    assign ld_row_ok = (int'(i_item.row_index) < MAX_CONSTRAINTS);
    assign ld_col_ok = (int'(i_item.column_index) < MAX_VARIABLES);
    assign i_item.ready = (r_state == S_IDLE);

    // Main sequencer. States alternate address and use phases, so a write
    // always lands before a read of the same entry.
    always_comb begin
        n_state = r_state;  n_clr = r_clr;    n_m = r_m;      n_n = r_n;
        n_i = r_i;          n_k = r_k;        n_j = r_j;      n_pc = r_pc;
        n_pr = r_pr;        n_brow = r_brow;  n_bcol = r_bcol;
        n_cok = r_cok;      n_rok = r_rok;    n_neg = r_neg;  n_bestv = r_bestv;
        n_t = r_t;          n_b = r_b;        n_tr = r_tr;    n_br = r_br;
        n_pe = r_pe;        n_rowv = r_rowv;  n_old = r_old;  n_p1 = r_p1;
        n_piv = r_piv;      n_stat = r_stat;
        n_ovalid = r_ovalid; n_ostat = r_ostat; n_oobj = r_oobj; n_opiv = r_opiv;
        we = 1'b0;          waddr = '0;       wdata = '0;     raddr = '0;
        cwe = 1'b0;         caddr = r_i;
        mul_start = 1'b0;   mul_a = '0;       mul_b = '0;
        div_start = 1'b0;   div_num = '0;

        if (o_res.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                we = 1'b1;
                waddr = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_item.valid) begin
                    wdata = i_item.value;
                    case (i_item.op)
                        OP_LOAD_COEF: begin
                            we = ld_row_ok && ld_col_ok;
                            waddr = f_addr(RW'(i_item.row_index) + 1'b1,
                                CW'(CW'(MAX_CONSTRAINTS) + CW'(i_item.column_index)));
                        end
                        OP_LOAD_BOUND: begin
                            we = ld_row_ok;
                            waddr = f_addr(RW'(i_item.row_index) + 1'b1, CW'(RHS_COL));
                        end
                        OP_LOAD_OBJ: begin
                            we = ld_col_ok;
                            waddr = f_addr('0,
                                CW'(CW'(MAX_CONSTRAINTS) + CW'(i_item.column_index)));
                        end
                        default: begin
                            // Solve: clamp the counts and start with the slack identity.
                            if (r_cfg.num_constraints == '0) begin
                                n_m = RW'(1);
                            end else if (int'(r_cfg.num_constraints) > MAX_CONSTRAINTS) begin
                                n_m = RW'(MAX_CONSTRAINTS);
                            end else begin
                                n_m = RW'(r_cfg.num_constraints);
                            end
                            if (r_cfg.num_variables == '0) begin
                                n_n = CW'(1);
                            end else if (int'(r_cfg.num_variables) > MAX_VARIABLES) begin
                                n_n = CW'(MAX_VARIABLES);
                            end else begin
                                n_n = CW'(r_cfg.num_variables);
                            end
                            n_i = '0;
                            n_piv = '0;
                            n_state = S_SLK;
                        end
                    endcase
                end
            end
            S_SLK: begin
                if (r_i < r_m) begin
                    we = 1'b1;
                    waddr = f_addr(r_i + 1'b1, CW'(r_i));
                    wdata = ONE;
                    n_i = r_i + 1'b1;
                end else begin
                    n_k = '0;
                    n_cok = 1'b0;
                    n_bestv = '0;
                    n_state = S_CRD;
                end
            end
            // Entering column: largest positive objective entry, last one on ties.
            S_CRD: begin
                raddr = f_addr('0, kcol);
                n_state = S_CUS;
            end
            S_CUS: begin
                if (!r_rdata[W-1] && r_rdata != '0 &&
                    $signed(r_rdata) >= $signed(r_bestv)) begin
                    n_bestv = r_rdata;
                    n_bcol = kcol;
                    n_cok = 1'b1;
                end
                n_k = r_k + 1'b1;
                n_state = (r_k + 1'b1 == CW'(CW'(r_m) + r_n)) ? S_CDEC : S_CRD;
            end
            S_CDEC: begin
                if (!r_cok) begin
                    n_stat = ST_OPTIMAL;
                    n_state = S_OBJ;
                end else if (r_piv >= r_cfg.iteration_cap) begin
                    n_stat = ST_ITER_LIMIT;
                    n_state = S_OBJ;
                end else begin
                    n_pc = r_bcol;
                    n_i = RW'(1);
                    n_rok = 1'b0;
                    n_state = S_RTR;
                end
            end
            // Leaving row: minimum ratio by exact cross products, first on ties.
            S_RTR: begin
                raddr = f_addr(r_i, r_pc);
                n_state = S_RTU;
            end
            S_RTU: begin
                n_t = r_rdata;
                n_state = (r_rdata[W-1] || r_rdata == '0) ? S_RNX : S_RBR;
            end
            S_RBR: begin
                raddr = f_addr(r_i, CW'(RHS_COL));
                n_state = S_RBU;
            end
            S_RBU: begin
                n_b = r_rdata;
                if (!r_rok) begin
                    n_rok = 1'b1;
                    n_brow = r_i;
                    n_br = r_rdata;
                    n_tr = r_t;
                    n_state = S_RNX;
                end else begin
                    mul_start = 1'b1;
                    mul_a = f_mag(r_rdata);
                    mul_b = r_tr;
                    n_neg = r_rdata[W-1];
                    n_state = S_RM1;
                end
            end
            S_RM1: begin
                if (mul_done) begin
                    n_p1 = sprod;
                    mul_start = 1'b1;
                    mul_a = f_mag(r_br);
                    mul_b = r_t;
                    n_neg = r_br[W-1];
                    n_state = S_RM2;
                end
            end
            S_RM2: begin
                if (mul_done) begin
                    if ($signed(r_p1) < $signed(sprod)) begin
                        n_brow = r_i;
                        n_br = r_b;
                        n_tr = r_t;
                    end
                    n_state = S_RNX;
                end
            end
            S_RNX: begin
                if (r_i == r_m) begin
                    if (!r_rok) begin
                        n_stat = ST_UNBOUNDED;
                        n_state = S_OBJ;
                    end else begin
                        n_pr = r_brow;
                        n_i = '0;
                        n_state = S_CVR;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_RTR;
                end
            end
            // Copy the entering column before the update overwrites it.
            S_CVR: begin
                raddr = f_addr(r_i, r_pc);
                n_state = S_CVU;
            end
            S_CVU: begin
                cwe = 1'b1;
                if (r_i == r_pr) begin
                    n_pe = r_rdata;
                end
                if (r_i == r_m) begin
                    n_j = '0;
                    n_state = S_PJR;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_CVR;
                end
            end
            // Pivot, one column at a time: divide the pivot row entry, then
            // update every row of that column.
            S_PJR: begin
                raddr = f_addr(r_pr, r_j);
                n_state = S_PJU;
            end
            S_PJU: begin
                div_start = 1'b1;
                div_num = {f_mag(r_rdata), 16'h0000};
                n_neg = r_rdata[W-1];
                n_state = S_PDV;
            end
            S_PDV: begin
                if (div_done) begin
                    n_rowv = qd_res;
                    n_i = '0;
                    n_state = S_PIR;
                end
            end
            S_PIR: begin
                raddr = f_addr(r_i, r_j);
                n_state = S_PIU;
            end
            S_PIU: begin
                if (r_i == r_pr) begin
                    we = 1'b1;
                    waddr = f_addr(r_i, r_j);
                    wdata = r_rowv;
                    n_state = S_PIN;
                end else begin
                    n_old = r_rdata;
                    mul_start = 1'b1;
                    mul_a = f_mag(r_crdata);
                    mul_b = f_mag(r_rowv);
                    n_neg = r_crdata[W-1] ^ r_rowv[W-1];
                    n_state = S_PMW;
                end
            end
            S_PMW: begin
                if (mul_done) begin
                    we = 1'b1;
                    waddr = f_addr(r_i, r_j);
                    wdata = f_sat_sub(r_old, qm_res);
                    n_state = S_PIN;
                end
            end
            S_PIN: begin
                if (r_i == r_m) begin
                    if (r_j == CW'(T_COLS - 1)) begin
                        n_piv = r_piv + 1'b1;
                        n_k = '0;
                        n_cok = 1'b0;
                        n_bestv = '0;
                        n_state = S_CRD;
                    end else begin
                        n_j = r_j + 1'b1;
                        n_state = S_PJR;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_PIR;
                end
            end
            // Result: wait for the output register, then clear the tableau.
            S_OBJ: begin
                raddr = f_addr('0, CW'(RHS_COL));
                if (!r_ovalid) begin
                    n_state = S_OBU;
                end
            end
            S_OBU: begin
                n_ovalid = 1'b1;
                n_ostat = r_stat;
                n_oobj = f_sat_sub('0, r_rdata);
                n_opiv = r_piv;
                n_clr = '0;
                n_state = S_CLR;
            end
            default: begin
                n_clr = '0;
                n_state = S_CLR;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
            r_piv <= '0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_ovalid <= n_ovalid;
            r_piv <= n_piv;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_m <= n_m;        r_n <= n_n;        r_i <= n_i;        r_k <= n_k;
        r_j <= n_j;        r_pc <= n_pc;      r_pr <= n_pr;      r_brow <= n_brow;
        r_bcol <= n_bcol;  r_cok <= n_cok;    r_rok <= n_rok;    r_neg <= n_neg;
        r_bestv <= n_bestv; r_t <= n_t;       r_b <= n_b;        r_tr <= n_tr;
        r_br <= n_br;      r_pe <= n_pe;      r_rowv <= n_rowv;  r_old <= n_old;
        r_p1 <= n_p1;      r_stat <= n_stat;  r_ostat <= n_ostat;
        r_oobj <= n_oobj;  r_opiv <= n_opiv;
    end

    assign o_res.valid = r_ovalid;
    assign o_res.status = r_ostat;
    assign o_res.objective_value = r_oobj;
    assign o_res.pivot_count = r_opiv;

    // A result appears only from the result state.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_OBU)
        else $error("result raised outside the result state");

    // Multiplier completions only arrive while the sequencer waits for them.
    a_mul_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_RM1 || r_state == S_RM2 || r_state == S_PMW))
        else $error("multiplier result arrived outside a wait state");

    // Divider completions only arrive in the division wait state.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_PDV)
        else $error("divider result arrived outside its wait state");

    // The pivot element is strictly positive whenever a division starts.
    a_pivot_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (!r_pe[W-1] && r_pe != '0))
        else $error("division started with a non-positive pivot");

endmodule

FILE: tb/sv/sts_tb_ifs.sv
// Shared package for the simplex tableau solver testbench.
// The interfaces come from the block's own interface file; this file only
// holds the testbench-side constants and types that the top module shares.
`timescale 1ns / 1ps
package sts_tb_pkg;
    import sts_pkg::*;

    // Fixed-point one in Q16.16.
    localparam int Q_ONE = 65536;

    // Cycles the block spends clearing its tableau after a solve, with margin.
    localparam int CLEAR_WAIT = 800;

    // Cycle count at which the run is abandoned.
    localparam int CYCLE_LIMIT = 8000000;

    // One input item waiting to be driven.
    typedef struct {
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [31:0]      value;
    } t_lp_item;

    // One predicted solver answer.
    typedef struct {
        logic [1:0]       status;
        logic [31:0]      objective;
        logic [PIV_W-1:0] pivots;
    } t_lp_answer;
endpackage

FILE: tb/sv/testbench.sv
// Testbench top for simplex_tableau_solver: drives load and solve items,
// predicts every answer with its own fixed-point simplex and checks it.
// Depends on sts_pkg, the block's channel interfaces and sts_tb_pkg.
`timescale 1ns / 1ps
module testbench import sts_pkg::*, sts_tb_pkg::*;;

    logic i_clk;
    logic i_rst_n;

    sts_item_if #(.VALUE_WIDTH(32)) item_if ();
    sts_res_if #(.VALUE_WIDTH(32)) res_if ();
    sts_cfg_if cfg_if ();

    simplex_tableau_solver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if.sink),
        .i_cfg   (cfg_if.sink),
        .o_res   (res_if.source)
    );

    // Predictor state: tableau copy and register copies.
    int               tab [0:16][0:32];
    logic [CNT_W-1:0] lp_rows;
    logic [CNT_W-1:0] lp_vars;
    logic [PIV_W-1:0] lp_cap;

    t_lp_item   pending_items[$];
    t_lp_answer expected_answers[$];
    int         mismatches = 0;
    int         answers_seen;
    int         items_queued;
    int         cycles = 0;
    int         send_gap;
    int         send_burst;
    int         recv_gap;
    int         hold_off;
    bit         hold_done;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Product floored, quotient truncated, both saturated.
    function automatic longint fx_mul(longint a, longint b);
        return sat32((a * b) >>> 16);
    endfunction

    function automatic longint fx_div(longint a, longint d);
        return sat32((a * 65536) / d);
    endfunction

    function automatic longint fx_sub(longint x, longint y);
        return sat32(x - y);
    endfunction

    // Run the simplex method on the tableau copy, return the answer, clear.
    task automatic solve_lp(output t_lp_answer ans);
        int     m, n, pc, pr, j, k, i, piv;
        longint bestv, v, t, pe;
        longint rowv [0:32];
        longint colv [0:16];
        m = (lp_rows < 1) ? 1 : ((lp_rows > 16) ? 16 : int'(lp_rows));
        n = (lp_vars < 1) ? 1 : ((lp_vars > 16) ? 16 : int'(lp_vars));
        for (i = 0; i < m; i++) tab[i + 1][i] = Q_ONE;
        piv = 0;
        forever begin
            // Entering column: largest positive entry, last one on ties.
            pc = -1;
            bestv = 0;
            for (k = 0; k < m + n; k++) begin
                j = (k < m) ? k : 16 + k - m;
                v = tab[0][j];
                if (v > 0 && v >= bestv) begin
                    bestv = v;
                    pc = j;
                end
            end
            if (pc < 0) begin
                ans.status = ST_OPTIMAL;
                break;
            end
            if (piv >= lp_cap) begin
                ans.status = ST_ITER_LIMIT;
                break;
            end
            // Leaving row: minimum ratio, first one on ties.
            pr = -1;
            for (i = 1; i <= m; i++) begin
                t = tab[i][pc];
                if (t > 0) begin
                    if (pr < 0 || longint'(tab[i][32]) * longint'(tab[pr][pc]) <
                            longint'(tab[pr][32]) * t)
                        pr = i;
                end
            end
            if (pr < 0) begin
                ans.status = ST_UNBOUNDED;
                break;
            end
            pe = tab[pr][pc];
            for (i = 0; i <= m; i++) colv[i] = tab[i][pc];
            for (j = 0; j < 33; j++) rowv[j] = fx_div(tab[pr][j], pe);
            for (i = 0; i <= m; i++)
                for (j = 0; j < 33; j++)
                    tab[i][j] = int'(fx_sub(tab[i][j], fx_mul(colv[i], rowv[j])));
            for (j = 0; j < 33; j++) tab[pr][j] = int'(rowv[j]);
            piv++;
        end
        ans.objective = 32'(fx_sub(0, tab[0][32]));
        ans.pivots = PIV_W'(piv);
        for (i = 0; i < 17; i++)
            for (j = 0; j < 33; j++) tab[i][j] = 0;
    endtask

    // Prediction on every accepted item transfer.
    always @(posedge i_clk) begin
        t_lp_answer ans;
        if (i_rst_n && item_if.valid && item_if.ready) begin
            case (item_if.op)
                OP_LOAD_COEF: tab[item_if.row_index + 1][16 + item_if.column_index] =
                    item_if.value;
                OP_LOAD_BOUND: tab[item_if.row_index + 1][32] = item_if.value;
                OP_LOAD_OBJ: tab[0][16 + item_if.column_index] = item_if.value;
                default: begin
                    solve_lp(ans);
                    expected_answers.push_back(ans);
                end
            endcase
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Item driver, fed from the pending queue.
    always @(posedge i_clk) begin
        t_lp_item it;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
            item_if.op <= OP_LOAD_COEF;
            item_if.row_index <= '0;
            item_if.column_index <= '0;
            item_if.value <= '0;
            send_gap <= 0;
            send_burst <= 0;
        end else if (!item_if.valid || item_if.ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                item_if.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                item_if.op <= it.op;
                item_if.row_index <= it.row;
                item_if.column_index <= it.col;
                item_if.value <= it.value;
                item_if.valid <= 1'b1;
                if (send_burst > 0) begin
                    send_burst <= send_burst - 1;
                    send_gap <= 0;
                end else if ($urandom_range(0, 19) == 0) begin
                    send_burst <= $urandom_range(20, 60);
                    send_gap <= 0;
                end else begin
                    send_gap <= pick_gap();
                end
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted on its own; it starts while plenty of
    // items are still waiting, so the block fills up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off <= 0;
            hold_done <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end else if (!hold_done && answers_seen >= 8 && pending_items.size() > 30) begin
            hold_off <= 4000;
            hold_done <= 1'b1;
        end
    end

    // Result monitor: random stalls and field-by-field checking.
    always @(posedge i_clk) begin
        t_lp_answer want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            recv_gap <= 0;
            answers_seen <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                answers_seen <= answers_seen + 1;
                if (expected_answers.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: status %0d value %h pivots %0d",
                                 res_if.status, res_if.objective_value,
                                 res_if.pivot_count);
                    mismatches++;
                end else begin
                    want = expected_answers.pop_front();
                    if (res_if.status !== want.status ||
                            res_if.objective_value !== want.objective ||
                            res_if.pivot_count !== want.pivots) begin
                        if (mismatches < 10)
                            $display("mismatch: expected %0d/%h/%0d, got %0d/%h/%0d",
                                     want.status, want.objective, want.pivots,
                                     res_if.status, res_if.objective_value,
                                     res_if.pivot_count);
                        mismatches++;
                    end
                end
            end
            if (hold_off > 0) begin
                res_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_item(logic [1:0] op, int row, int col, logic [31:0] value);
        t_lp_item it;
        it.op = op;
        it.row = IDX_W'(row);
        it.col = IDX_W'(col);
        it.value = value;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Wait until every item is sent and answered, then let the clear finish.
    // The check runs at the falling edge, after the driver has settled.
    task automatic wait_idle();
        while (pending_items.size() > 0 || item_if.valid || expected_answers.size() > 0)
            @(negedge i_clk);
        repeat (CLEAR_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_NUM_CONSTRAINTS: lp_rows = data[CNT_W-1:0];
            CFG_NUM_VARIABLES: lp_vars = data[CNT_W-1:0];
            CFG_ITERATION_CAP: lp_cap = data;
            default: ;
        endcase
    endtask

    task automatic set_regs(int rows, int vars, int cap);
        write_reg(CFG_NUM_CONSTRAINTS, CFG_DW'(rows));
        write_reg(CFG_NUM_VARIABLES, CFG_DW'(vars));
        write_reg(CFG_ITERATION_CAP, CFG_DW'(cap));
    endtask

    // One random problem: noise loads, a well-formed program, then a solve.
    task automatic random_problem();
        int m, n, r, c, k;
        m = (lp_rows < 1) ? 1 : ((lp_rows > 16) ? 16 : int'(lp_rows));
        n = (lp_vars < 1) ? 1 : ((lp_vars > 16) ? 16 : int'(lp_vars));
        for (k = $urandom_range(10, 30); k > 0; k--)
            push_item(2'($urandom_range(0, 2)), $urandom_range(0, 15),
                      $urandom_range(0, 15), $urandom());
        for (r = 0; r < m; r++) begin
            for (c = 0; c < n; c++)
                push_item(OP_LOAD_COEF, r, c, $urandom_range(0, 8 * Q_ONE) - Q_ONE);
            push_item(OP_LOAD_BOUND, r, 0, $urandom_range(0, 20 * Q_ONE));
        end
        for (c = 0; c < n; c++)
            push_item(OP_LOAD_OBJ, 0, c, $urandom_range(0, 10 * Q_ONE) - 2 * Q_ONE);
        if ($urandom_range(0, 9) == 0)
            for (k = $urandom_range(1, 4); k > 0; k--)
                push_item(2'($urandom_range(0, 2)), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom());
        push_item(OP_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom());
    endtask

    // Stimulus sequence.
    initial begin
        int sel, rows, cap, k;
        items_queued = 0;
        lp_rows = RST_NUM_CONSTRAINTS;
        lp_vars = RST_NUM_VARIABLES;
        lp_cap = RST_ITERATION_CAP;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (CLEAR_WAIT) @(posedge i_clk);

        // Directed: a plain bounded program, an empty tableau, an unbounded one.
        push_item(OP_LOAD_COEF, 0, 0, 2 * Q_ONE);
        push_item(OP_LOAD_BOUND, 0, 0, 4 * Q_ONE);
        push_item(OP_LOAD_OBJ, 0, 0, 3 * Q_ONE);
        push_item(OP_SOLVE, 0, 0, 0);
        push_item(OP_SOLVE, 15, 15, 32'hffff_ffff);
        push_item(OP_LOAD_OBJ, 0, 0, Q_ONE);
        push_item(OP_LOAD_COEF, 0, 0, -Q_ONE);
        push_item(OP_SOLVE, 0, 0, 0);
        // Extreme values, a negative bound and loads beyond the counts.
        push_item(OP_LOAD_COEF, 0, 0, 32'h7fff_ffff);
        push_item(OP_LOAD_BOUND, 0, 0, 32'h8000_0000);
        push_item(OP_LOAD_OBJ, 0, 0, 32'h7fff_ffff);
        push_item(OP_LOAD_COEF, 15, 15, 32'h8000_0000);
        push_item(OP_LOAD_OBJ, 0, 15, 32'h7fff_ffff);
        push_item(OP_SOLVE, 0, 0, 0);
        wait_idle();

        // Zero counts are clamped up; a zero cap stops before any pivot.
        set_regs(0, 0, 0);
        push_item(OP_LOAD_COEF, 0, 0, Q_ONE);
        push_item(OP_LOAD_BOUND, 0, 0, Q_ONE);
        push_item(OP_LOAD_OBJ, 0, 0, Q_ONE);
        push_item(OP_SOLVE, 0, 0, 0);
        wait_idle();

        // Oversized counts are clamped to the maximum; one pivot allowed.
        set_regs(31, 31, 1);
        push_item(OP_LOAD_COEF, 15, 15, 3 * Q_ONE);
        push_item(OP_LOAD_BOUND, 15, 0, 9 * Q_ONE);
        push_item(OP_LOAD_OBJ, 0, 15, 5 * Q_ONE);
        push_item(OP_SOLVE, 0, 0, 0);
        wait_idle();

        // Largest cap on a tiny program.
        set_regs(1, 1, 65535);
        push_item(OP_LOAD_COEF, 0, 0, Q_ONE);
        push_item(OP_LOAD_BOUND, 0, 0, Q_ONE);
        push_item(OP_LOAD_OBJ, 0, 0, Q_ONE);
        push_item(OP_SOLVE, 0, 0, 0);
        wait_idle();

        // Random phases, each with its own register settings.
        while (items_queued < 1950) begin
            sel = $urandom_range(0, 19);
            cap = $urandom_range(1, 6);
            if (sel == 0) begin
                rows = 0;
            end else if (sel == 1) begin
                rows = $urandom_range(17, 31);
                cap = $urandom_range(0, 1);
            end else begin
                rows = $urandom_range(1, 3);
            end
            if ($urandom_range(0, 9) == 0) cap = 0;
            // Upper data bits of the count registers are random as well.
            set_regs(rows | ($urandom_range(0, 2047) << CNT_W),
                     $urandom_range(0, 31) | ($urandom_range(0, 2047) << CNT_W), cap);
            for (k = $urandom_range(2, 5); k > 0; k--) random_problem();
            wait_idle();
        end

        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/sts_pkg.sv
rtl/sts_ifs.sv
rtl/sts_mul.sv
rtl/sts_div.sv
rtl/simplex_tableau_solver.sv
tb/sv/sts_tb_ifs.sv
tb/sv/testbench.sv
